// ===== design/phmap_pkg.sv =====
`timescale 1ns / 1ps

package phmap_pkg;

   // Field widths of the request and response beats.
   localparam int ROW_W   = 6;
   localparam int GROUP_W = 9;
   localparam int COUNT_W = 6;

   // Configuration register widths.
   localparam int CELL_W  = 9;
   localparam int RB_W    = 7;
   localparam int RF_W    = 4;
   localparam int CTRL_W  = 36;
   localparam int FIRST_W = 2;
   localparam int PCF_N   = 4;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 36;

   // Mapping constants.
   localparam int MAX_ROWS      = 56;
   localparam int COUNT_MAX     = (1 << COUNT_W) - 1;
   localparam int MIN_RB        = 6;
   localparam int PRB_PER_GROUP = 48;
   localparam int N0_OFFSET     = 4;
   localparam int THIRDS        = 3;
   localparam int LANES         = 3;

   // Widths of the per-configuration constants.
   localparam int N0_W   = 8;
   localparam int N1_W   = 9;
   localparam int T1_W   = 7;
   localparam int T2_W   = 8;
   localparam int BASE_W = 11;

   // Serial divider used to work out the cell offsets.
   localparam int NUM_W     = 18;
   localparam int DEN_W     = 9;
   localparam int DIV_STEPS = NUM_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // Divisions by three by reciprocal multiplication. The short form is exact
   // below 512 and the long form below 2048. The group size is three times 16.
   localparam int GROUP_SHIFT = 4;
   localparam int RECIP3_S    = 171;
   localparam int RECIP3_S_SH = 9;
   localparam int RECIP3_L    = 683;
   localparam int RECIP3_L_SH = 11;
   localparam int MUL_W       = 19;
   localparam int PROD_W      = RF_W + RB_W + 1;
   localparam int CNT_SAT_W   = COUNT_W + 1;

   // Width of the pre-reduction sums in the pipeline and of the reduction compare.
   localparam int X_W   = 10;
   localparam int MOD_W = DEN_W + 3;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_CELL_ID     = 3'd0,
      CSR_NUM_RB      = 3'd1,
      CSR_RES_FACTOR  = 3'd2,
      CSR_EXT_PREFIX  = 3'd3,
      CSR_CTRL_REGS   = 3'd4,
      CSR_CTRL_FIRST  = 3'd5
   } phmap_csr_type;

   // Everything the pipeline needs from the configuration side.
   typedef struct packed {
      logic                             ready;
      logic                             ext;
      logic [RB_W-1:0]                  rb;
      logic [N0_W-1:0]                  n0;
      logic [N1_W-1:0]                  n1;
      logic [T1_W-1:0]                  t1n;
      logic [T2_W-1:0]                  t2n;
      logic [N0_W-1:0]                  cnorm;
      logic [N0_W-1:0]                  cm0;
      logic [N1_W-1:0]                  bm1;
      logic [COUNT_W-1:0]               group_count;
      logic [PCF_N-1:0][GROUP_W-1:0]    pcf;
   } phmap_cfg_type;

endpackage

// ===== design/phmap_req_if.sv =====
`timescale 1ns / 1ps

interface phmap_req_if;
   import phmap_pkg::*;

   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] row_index;

   modport source (output valid, output row_index, input ready);
   modport sink   (input valid, input row_index, output ready);
endinterface

// ===== design/phmap_rsp_if.sv =====
`timescale 1ns / 1ps

interface phmap_rsp_if;
   import phmap_pkg::*;

   logic               valid;
   logic               ready;
   logic [GROUP_W-1:0] group_first;
   logic [GROUP_W-1:0] group_second;
   logic [GROUP_W-1:0] group_third;
   logic               row_valid;
   logic [COUNT_W-1:0] group_count;

   modport source (output valid, output group_first, output group_second,
                   output group_third, output row_valid, output group_count,
                   input ready);
   modport sink   (input valid, input group_first, input group_second,
                   input group_third, input row_valid, input group_count,
                   output ready);
endinterface

// ===== design/phmap_setup.sv =====
`timescale 1ns / 1ps

module phmap_setup (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [phmap_pkg::CSR_ADDR_W-1:0]    csr_index,
   input  logic [phmap_pkg::CSR_DATA_W-1:0]    csr_write_data,
   output phmap_pkg::phmap_cfg_type            cfg
);
   import phmap_pkg::*;

   typedef enum logic [1:0] {SEQ_IDLE, SEQ_LOAD, SEQ_DIV, SEQ_STORE} seq_state_type;
   typedef enum logic [1:0] {JOB_CNORM, JOB_CM0, JOB_BASE, JOB_BM1} job_type;

   logic [CELL_W-1:0]  cell_id_ff, cell_id_in;
   logic [RB_W-1:0]    num_rb_ff, num_rb_in;
   logic [RF_W-1:0]    rf_ff, rf_in;
   logic               ext_ff, ext_in;
   logic [CTRL_W-1:0]  ctrl_regs_ff, ctrl_regs_in;
   logic [FIRST_W-1:0] ctrl_first_ff, ctrl_first_in;

   seq_state_type      state_ff, state_in;
   job_type            job_ff, job_in;
   logic               dirty_ff, dirty_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   logic [NUM_W-1:0]   num_ff, num_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [DEN_W-1:0]   rem_ff, rem_in;
   logic [T1_W-1:0]    t1n_ff, t1n_in;
   logic [T2_W-1:0]    t2n_ff, t2n_in;
   logic [N0_W-1:0]    cnorm_ff, cnorm_in;
   logic [N0_W-1:0]    cm0_ff, cm0_in;
   logic [BASE_W-1:0]  base_ff, base_in;
   logic [N1_W-1:0]    bm1_ff, bm1_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;

   logic [RB_W-1:0]    rb_eff;
   logic [N0_W-1:0]    n0;
   logic [N1_W-1:0]    n1;
   logic [DEN_W:0]     rem_sh;
   logic               rem_ge;
   logic [MUL_W-1:0]   cnt_mul;
   logic [MUL_W-1:0]   t1_mul;
   logic [MUL_W-1:0]   t2_mul;
   logic [COUNT_W-1:0] cnt_quot;
   logic [CNT_SAT_W-1:0] cnt_sat;
   logic [PCF_N-1:0][GROUP_W-1:0] ctrl_entries;

   // Bandwidths below the minimum are treated as the minimum.
   assign rb_eff = (num_rb_ff < RB_W'(MIN_RB)) ? RB_W'(MIN_RB) : num_rb_ff;
   assign n0     = {rb_eff, 1'b0} - N0_W'(N0_OFFSET);
   assign n1     = N1_W'(N1_W'(rb_eff) * N1_W'(THIRDS));

   // One restoring step: the quotient bits shift into the numerator register.
   assign rem_sh = {rem_ff, num_ff[NUM_W-1]};
   assign rem_ge = rem_sh >= {1'b0, den_ff};

   assign ctrl_entries = ctrl_regs_ff;

   // The group count and the thirds of n0 divide by constants, so they are
   // formed by reciprocal multiplication; the count takes two register stages.
   always_comb begin
      prod_in  = PROD_W'(PROD_W'(rf_ff) * PROD_W'(rb_eff)) + PROD_W'(PRB_PER_GROUP - 1);
      cnt_mul  = MUL_W'(prod_ff[PROD_W-1:GROUP_SHIFT]) * MUL_W'(RECIP3_S);
      cnt_quot = cnt_mul[RECIP3_S_SH +: COUNT_W];
      cnt_sat  = ext_ff ? {cnt_quot, 1'b0} : {1'b0, cnt_quot};
      if (cnt_sat > CNT_SAT_W'(MAX_ROWS)) begin
         cnt_sat = CNT_SAT_W'(MAX_ROWS);
      end
      if (cnt_sat > CNT_SAT_W'(COUNT_MAX)) begin
         cnt_sat = CNT_SAT_W'(COUNT_MAX);
      end
      count_in = cnt_sat[COUNT_W-1:0];
      t1_mul   = MUL_W'(n0) * MUL_W'(RECIP3_S);
      t1n_in   = t1_mul[RECIP3_S_SH +: T1_W];
      t2_mul   = MUL_W'({n0, 1'b0}) * MUL_W'(RECIP3_L);
      t2n_in   = t2_mul[RECIP3_L_SH +: T2_W];
   end

   always_comb begin
      cell_id_in    = cell_id_ff;
      num_rb_in     = num_rb_ff;
      rf_in         = rf_ff;
      ext_in        = ext_ff;
      ctrl_regs_in  = ctrl_regs_ff;
      ctrl_first_in = ctrl_first_ff;
      state_in      = state_ff;
      job_in        = job_ff;
      dirty_in      = dirty_ff;
      step_in       = step_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      cnorm_in      = cnorm_ff;
      cm0_in        = cm0_ff;
      base_in       = base_ff;
      bm1_in        = bm1_ff;

      unique case (state_ff)
         SEQ_IDLE: begin
            if (dirty_ff) begin
               dirty_in = 1'b0;
               job_in   = JOB_CNORM;
               state_in = SEQ_LOAD;
            end
         end
         SEQ_LOAD: begin
            rem_in   = '0;
            step_in  = STEP_W'(DIV_STEPS - 1);
            state_in = SEQ_DIV;
            unique case (job_ff)
               JOB_CNORM: begin
                  num_in = NUM_W'(cell_id_ff) + NUM_W'(1);
                  den_in = DEN_W'(n0);
               end
               JOB_CM0: begin
                  num_in = NUM_W'(cell_id_ff);
                  den_in = DEN_W'(n0);
               end
               JOB_BASE: begin
                  num_in = NUM_W'(NUM_W'(cell_id_ff) * NUM_W'(n1));
                  den_in = DEN_W'(n0);
               end
               JOB_BM1: begin
                  num_in = NUM_W'(base_ff);
                  den_in = DEN_W'(n1);
               end
               default: begin
                  num_in = num_ff;
                  den_in = den_ff;
               end
            endcase
         end
         SEQ_DIV: begin
            rem_in = rem_ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : DEN_W'(rem_sh);
            num_in = {num_ff[NUM_W-2:0], rem_ge};
            if (step_ff == '0) begin
               state_in = SEQ_STORE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         SEQ_STORE: begin
            unique case (job_ff)
               JOB_CNORM: cnorm_in = rem_ff[N0_W-1:0];
               JOB_CM0:   cm0_in   = rem_ff[N0_W-1:0];
               JOB_BASE:  base_in  = num_ff[BASE_W-1:0];
               JOB_BM1:   bm1_in   = rem_ff[N1_W-1:0];
               default:   cnorm_in = cnorm_ff;
            endcase
            if (job_ff == JOB_BM1) begin
               state_in = SEQ_IDLE;
            end else begin
               job_in   = job_type'(job_ff + 1'b1);
               state_in = SEQ_LOAD;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase

      // A register write aborts any run and starts the constants over.
      if (csr_write_en) begin
         dirty_in = 1'b1;
         state_in = SEQ_IDLE;
         unique case (phmap_csr_type'(csr_index))
            CSR_CELL_ID:    cell_id_in    = csr_write_data[CELL_W-1:0];
            CSR_NUM_RB:     num_rb_in     = csr_write_data[RB_W-1:0];
            CSR_RES_FACTOR: rf_in         = csr_write_data[RF_W-1:0];
            CSR_EXT_PREFIX: ext_in        = csr_write_data[0];
            CSR_CTRL_REGS:  ctrl_regs_in  = csr_write_data[CTRL_W-1:0];
            CSR_CTRL_FIRST: ctrl_first_in = csr_write_data[FIRST_W-1:0];
            default:        cell_id_in    = cell_id_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_id_ff    <= '0;
         num_rb_ff     <= RB_W'(MIN_RB);
         rf_ff         <= RF_W'(6);
         ext_ff        <= 1'b0;
         ctrl_regs_ff  <= '0;
         ctrl_first_ff <= '0;
         state_ff      <= SEQ_IDLE;
         job_ff        <= JOB_CNORM;
         dirty_ff      <= 1'b1;
         step_ff       <= '0;
      end else begin
         cell_id_ff    <= cell_id_in;
         num_rb_ff     <= num_rb_in;
         rf_ff         <= rf_in;
         ext_ff        <= ext_in;
         ctrl_regs_ff  <= ctrl_regs_in;
         ctrl_first_ff <= ctrl_first_in;
         state_ff      <= state_in;
         job_ff        <= job_in;
         dirty_ff      <= dirty_in;
         step_ff       <= step_in;
      end
      num_ff   <= num_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      t1n_ff   <= t1n_in;
      t2n_ff   <= t2n_in;
      cnorm_ff <= cnorm_in;
      cm0_ff   <= cm0_in;
      base_ff  <= base_in;
      bm1_ff   <= bm1_in;
      count_ff <= count_in;
      prod_ff  <= prod_in;
   end

   always_comb begin
      cfg.ready       = (state_ff == SEQ_IDLE) && !dirty_ff;
      cfg.ext         = ext_ff;
      cfg.rb          = rb_eff;
      cfg.n0          = n0;
      cfg.n1          = n1;
      cfg.t1n         = t1n_ff;
      cfg.t2n         = t2n_ff;
      cfg.cnorm       = cnorm_ff;
      cfg.cm0         = cm0_ff;
      cfg.bm1         = bm1_ff;
      cfg.group_count = count_ff;
      // PCFICH entries in the order they are compared.
      for (int k = 0; k < PCF_N; k++) begin
         cfg.pcf[k] = ctrl_entries[FIRST_W'(ctrl_first_ff + FIRST_W'(k))];
      end
   end

endmodule

// ===== design/phich_reg_group_mapper_top.sv =====
`timescale 1ns / 1ps

// PHICH resource element group mapper. Each request beat carries a PHICH table
// row; each response beat gives that row's three REG indices, a flag that is
// set when the row lies below the configured group count, and the group count
// itself (zeros in the three indices when the row is not valid). Rows flow
// through a five-stage pipeline: one row is accepted per clock unless the
// constants are being worked out or the pipeline is full and stalled. A
// stall on the response side holds each occupied stage that has no empty
// stage after it; stages behind a gap move on. The group count and the
// thirds of n0 come from reciprocal multiplication; the cell offsets taken mod
// n0 and mod n1 are worked out by a shared 18-step serial divider over four
// jobs. After reset and after every CSR write, req_chan.ready stays low while
// that runs. CSR writes are expected only while no beat is in flight.
module phich_reg_group_mapper_top (
   input  logic                             clock,
   input  logic                             reset,
   phmap_req_if.sink                        req_chan,
   phmap_rsp_if.source                      rsp_chan,
   input  logic                             csr_write_en,
   input  logic [phmap_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [phmap_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import phmap_pkg::*;

   phmap_cfg_type cfg;

   phmap_setup u_setup (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   // Lane 0 always reduces by n0; in extended prefix the other lanes use n1.
   function automatic logic [DEN_W-1:0] lane_div(input int lane, input phmap_cfg_type c);
      return (c.ext && lane != 0) ? DEN_W'(c.n1) : DEN_W'(c.n0);
   endfunction

   function automatic logic [X_W-1:0] cond_sub(input logic [X_W-1:0] x,
                                               input logic [DEN_W-1:0] d,
                                               input logic [1:0] sh);
      logic [MOD_W-1:0] dd;
      logic [MOD_W-1:0] xx;
      dd = MOD_W'(d) << sh;
      xx = MOD_W'(x);
      if (xx >= dd) begin
         xx = xx - dd;
      end
      return xx[X_W-1:0];
   endfunction

   function automatic logic [GROUP_W-1:0] bump(input logic [GROUP_W-1:0] v,
                                               input logic [GROUP_W-1:0] e);
      return (v >= e) ? v + 1'b1 : v;
   endfunction

   // Stage registers. Each stage carries its own valid bit.
   logic                                s1_valid_ff, s1_valid_in;
   logic                                s1_hit_ff, s1_hit_in;
   logic [LANES-1:0][X_W-1:0]           s1_x_ff, s1_x_in;
   logic                                s2_valid_ff, s2_valid_in;
   logic                                s2_hit_ff, s2_hit_in;
   logic [LANES-1:0][X_W-1:0]           s2_x_ff, s2_x_in;
   logic                                s3_valid_ff, s3_valid_in;
   logic                                s3_hit_ff, s3_hit_in;
   logic [LANES-1:0][GROUP_W-1:0]       s3_g_ff, s3_g_in;
   logic                                s4_valid_ff, s4_valid_in;
   logic                                s4_hit_ff, s4_hit_in;
   logic [LANES-1:0][GROUP_W-1:0]       s4_g_ff, s4_g_in;
   logic                                out_valid_ff, out_valid_in;
   logic                                out_hit_ff, out_hit_in;
   logic [COUNT_W-1:0]                  out_count_ff, out_count_in;
   logic [LANES-1:0][GROUP_W-1:0]       out_g_ff, out_g_in;

   logic s1_en, s2_en, s3_en, s4_en, out_en;
   logic accept;
   logic [ROW_W-2:0] pair;
   logic [X_W-1:0]   x_tmp;
   logic [GROUP_W-1:0] g_tmp;

   // A stage may load when it is empty or when the stage after it moves on.
   assign out_en = !out_valid_ff || rsp_chan.ready;
   assign s4_en  = !s4_valid_ff || out_en;
   assign s3_en  = !s3_valid_ff || s4_en;
   assign s2_en  = !s2_valid_ff || s3_en;
   assign s1_en  = !s1_valid_ff || s2_en;

   assign req_chan.ready = cfg.ready && s1_en;
   assign accept         = req_chan.valid && req_chan.ready;
   assign pair           = req_chan.row_index[ROW_W-1:1];

   // Stage 1: form the sums whose remainders are wanted.
   always_comb begin
      s1_valid_in = s1_en ? accept : s1_valid_ff;
      s1_hit_in   = s1_hit_ff;
      s1_x_in     = s1_x_ff;
      if (s1_en) begin
         s1_hit_in = req_chan.row_index < cfg.group_count;
         if (cfg.ext) begin
            s1_x_in[0] = X_W'(cfg.cm0) + X_W'(pair);
            s1_x_in[1] = X_W'(cfg.bm1) + X_W'(pair) + X_W'(cfg.rb);
            s1_x_in[2] = X_W'(cfg.bm1) + X_W'(pair) + X_W'({cfg.rb, 1'b0});
         end else begin
            s1_x_in[0] = X_W'(cfg.cnorm) + X_W'(req_chan.row_index);
            s1_x_in[1] = X_W'(cfg.cnorm) + X_W'(req_chan.row_index) + X_W'(cfg.t1n);
            s1_x_in[2] = X_W'(cfg.cnorm) + X_W'(req_chan.row_index) + X_W'(cfg.t2n);
         end
      end
   end

   // Stages 2 and 3: every sum is below sixteen times its divisor, so four
   // conditional subtractions of 8d, 4d, 2d and d leave the remainder.
   always_comb begin
      s2_valid_in = s2_en ? s1_valid_ff : s2_valid_ff;
      s2_hit_in   = s2_hit_ff;
      s2_x_in     = s2_x_ff;
      s3_valid_in = s3_en ? s2_valid_ff : s3_valid_ff;
      s3_hit_in   = s3_hit_ff;
      s3_g_in     = s3_g_ff;
      x_tmp       = '0;
      if (s2_en) begin
         s2_hit_in = s1_hit_ff;
         for (int i = 0; i < LANES; i++) begin
            x_tmp      = cond_sub(s1_x_ff[i], lane_div(i, cfg), 2'd3);
            s2_x_in[i] = cond_sub(x_tmp, lane_div(i, cfg), 2'd2);
         end
      end
      if (s3_en) begin
         s3_hit_in = s2_hit_ff;
         for (int i = 0; i < LANES; i++) begin
            x_tmp      = cond_sub(s2_x_ff[i], lane_div(i, cfg), 2'd1);
            x_tmp      = cond_sub(x_tmp, lane_div(i, cfg), 2'd0);
            s3_g_in[i] = x_tmp[GROUP_W-1:0];
         end
      end
   end

   // Stages 4 and 5: with normal prefix, step each index past the PCFICH
   // groups, two entries per stage. Invalid rows are forced to zero on output.
   always_comb begin
      s4_valid_in  = s4_en ? s3_valid_ff : s4_valid_ff;
      s4_hit_in    = s4_hit_ff;
      s4_g_in      = s4_g_ff;
      out_valid_in = out_en ? s4_valid_ff : out_valid_ff;
      out_hit_in   = out_hit_ff;
      out_count_in = out_count_ff;
      out_g_in     = out_g_ff;
      g_tmp        = '0;
      if (s4_en) begin
         s4_hit_in = s3_hit_ff;
         for (int i = 0; i < LANES; i++) begin
            g_tmp = s3_g_ff[i];
            if (!cfg.ext) begin
               g_tmp = bump(g_tmp, cfg.pcf[0]);
               g_tmp = bump(g_tmp, cfg.pcf[1]);
            end
            s4_g_in[i] = g_tmp;
         end
      end
      if (out_en) begin
         out_hit_in   = s4_hit_ff;
         out_count_in = cfg.group_count;
         for (int i = 0; i < LANES; i++) begin
            g_tmp = s4_g_ff[i];
            if (!cfg.ext) begin
               g_tmp = bump(g_tmp, cfg.pcf[2]);
               g_tmp = bump(g_tmp, cfg.pcf[3]);
            end
            out_g_in[i] = s4_hit_ff ? g_tmp : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_hit_ff    <= s1_hit_in;
      s1_x_ff      <= s1_x_in;
      s2_hit_ff    <= s2_hit_in;
      s2_x_ff      <= s2_x_in;
      s3_hit_ff    <= s3_hit_in;
      s3_g_ff      <= s3_g_in;
      s4_hit_ff    <= s4_hit_in;
      s4_g_ff      <= s4_g_in;
      out_hit_ff   <= out_hit_in;
      out_count_ff <= out_count_in;
      out_g_ff     <= out_g_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.group_first  = out_g_ff[0];
   assign rsp_chan.group_second = out_g_ff[1];
   assign rsp_chan.group_third  = out_g_ff[2];
   assign rsp_chan.row_valid    = out_hit_ff;
   assign rsp_chan.group_count  = out_count_ff;

endmodule

// ===== verif/phich_reg_group_mapper_top_tb.sv =====
`timescale 1ns / 1ps

module phich_reg_group_mapper_top_tb;
   import phmap_pkg::*;

   // Idle styles for the request and response sides, chosen per phase.
   localparam int IDLE_NONE  = 0;
   localparam int IDLE_LIGHT = 1;
   localparam int IDLE_FULL  = 2;
   localparam int MAX_IDLE   = 18;

   // The response side holds off this long once, which is far longer than the
   // five pipeline stages, so the block has to stop taking request beats.
   localparam int RSP_HOLD_CYCLES = 300;

   // Cycles allowed after the last response before the next CSR write or the
   // end of the run; the pipeline is five stages deep.
   localparam int DRAIN_CYCLES = 12;

   localparam int RANDOM_ROWS = 1250;

   // Reset value of the resource factor register (Ng = 1).
   localparam int RF_RESET = 6;

   // One response beat, as seen on the response channel or as predicted.
   typedef struct packed {
      logic [GROUP_W-1:0] first;
      logic [GROUP_W-1:0] second;
      logic [GROUP_W-1:0] third;
      logic               row_valid;
      logic [COUNT_W-1:0] count;
   } group_beat_type;

   // Keeps a private copy of the CSRs, works out the REG indices of every row
   // accepted on the request side, and checks the response beats in order.
   class reg_group_checker;
      bit [CELL_W-1:0]  cell_id;
      bit [RB_W-1:0]    num_rb;
      bit [RF_W-1:0]    res_factor;
      bit               ext_prefix;
      bit [CTRL_W-1:0]  pcfich_regs;
      bit [FIRST_W-1:0] pcfich_first;
      group_beat_type   pending_groups[$];
      int               mismatch_count;

      function new();
         cell_id        = '0;
         num_rb         = RB_W'(MIN_RB);
         res_factor     = RF_W'(RF_RESET);
         ext_prefix     = 1'b0;
         pcfich_regs    = '0;
         pcfich_first   = '0;
         mismatch_count = 0;
      endfunction

      function void set_reg(phmap_csr_type idx, bit [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_CELL_ID:    cell_id      = data[CELL_W-1:0];
            CSR_NUM_RB:     num_rb       = data[RB_W-1:0];
            CSR_RES_FACTOR: res_factor   = data[RF_W-1:0];
            CSR_EXT_PREFIX: ext_prefix   = data[0];
            CSR_CTRL_REGS:  pcfich_regs  = data[CTRL_W-1:0];
            CSR_CTRL_FIRST: pcfich_first = data[FIRST_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned eff_rb();
         return (num_rb < MIN_RB) ? MIN_RB : num_rb;
      endfunction

      function int unsigned group_total();
         int unsigned total;
         total = (res_factor * eff_rb() + PRB_PER_GROUP - 1) / PRB_PER_GROUP;
         if (ext_prefix)
            total = total << 1;
         if (total > MAX_ROWS)
            total = MAX_ROWS;
         if (total > COUNT_MAX)
            total = COUNT_MAX;
         return total;
      endfunction

      // Each PCFICH REG that the index reaches or passes pushes it up by one.
      function int unsigned bump_past_pcfich(int unsigned v);
         int unsigned      k;
         bit [1:0]         slot;
         bit [GROUP_W-1:0] entry;
         for (k = 0; k < PCF_N; k++) begin
            slot  = pcfich_first + k[1:0];
            entry = pcfich_regs[slot*GROUP_W +: GROUP_W];
            if (v >= entry)
               v++;
         end
         return v;
      endfunction

      function group_beat_type map_row_groups(bit [ROW_W-1:0] row);
         int unsigned rb, n0, n1, total, half, base;
         int unsigned g[3];
         int          i;
         group_beat_type beat;
         rb    = eff_rb();
         n0    = 2 * rb - N0_OFFSET;
         n1    = 3 * rb;
         total = group_total();
         g     = '{0, 0, 0};
         if (row < total) begin
            if (!ext_prefix) begin
               for (i = 0; i < 3; i++)
                  g[i] = bump_past_pcfich((1 + cell_id + row + (i * n0) / THIRDS) % n0);
            end else begin
               half = row >> 1;
               base = (cell_id * n1) / n0;
               g[0] = (cell_id + half) % n0;
               for (i = 1; i < 3; i++)
                  g[i] = (base + half + (i * n1) / THIRDS) % n1;
            end
         end
         beat.first     = GROUP_W'(g[0]);
         beat.second    = GROUP_W'(g[1]);
         beat.third     = GROUP_W'(g[2]);
         beat.row_valid = (row < total);
         beat.count     = COUNT_W'(total);
         return beat;
      endfunction

      function void note_row(bit [ROW_W-1:0] row);
         pending_groups.push_back(map_row_groups(row));
      endfunction

      task report_mismatch(string msg);
         mismatch_count++;
         $display("%0t ns: %s", $time, msg);
      endtask

      task check_beat(group_beat_type got);
         group_beat_type want;
         if (pending_groups.size() == 0) begin
            report_mismatch("response beat arrived with no row pending");
            return;
         end
         want = pending_groups.pop_front();
         if (got.first !== want.first)
            report_mismatch($sformatf("group_first got %0d, want %0d",
                                      got.first, want.first));
         if (got.second !== want.second)
            report_mismatch($sformatf("group_second got %0d, want %0d",
                                      got.second, want.second));
         if (got.third !== want.third)
            report_mismatch($sformatf("group_third got %0d, want %0d",
                                      got.third, want.third));
         if (got.row_valid !== want.row_valid)
            report_mismatch($sformatf("row_valid got %0b, want %0b",
                                      got.row_valid, want.row_valid));
         if (got.count !== want.count)
            report_mismatch($sformatf("group_count got %0d, want %0d",
                                      got.count, want.count));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_en;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   phmap_req_if req_chan ();
   phmap_rsp_if rsp_chan ();

   reg_group_checker groups = new();

   // Set by the stimulus; rsp_mode and hold_rsp are also read by the response process.
   int req_mode;
   int rsp_mode;
   bit hold_rsp;
   int rows_sent;

   phich_reg_group_mapper_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Every beat is sampled at the rising edge, before any of the nonblocking
   // updates made at that edge, so both monitors see settled values.
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         groups.note_row(req_chan.row_index);
   end

   always @(posedge clock) begin : rsp_monitor
      group_beat_type seen;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen.first     = rsp_chan.group_first;
         seen.second    = rsp_chan.group_second;
         seen.third     = rsp_chan.group_third;
         seen.row_valid = rsp_chan.row_valid;
         seen.count     = rsp_chan.group_count;
         groups.check_beat(seen);
      end
   end

   // Number of idle cycles in front of one beat. The light style leaves most
   // beats back to back, which keeps long stretches with no idling at all.
   function automatic int draw_gap(int mode);
      case (mode)
         IDLE_FULL:  return $urandom_range(MAX_IDLE, 0);
         IDLE_LIGHT: return ($urandom_range(7, 0) == 0) ? $urandom_range(MAX_IDLE, 0) : 0;
         default:    return 0;
      endcase
   endfunction

   // Response side. Before each beat it draws a stall; once per run the
   // stimulus asks for a long hold-off, which this process counts itself.
   initial begin : rsp_driver
      int gap;
      rsp_chan.ready = 1'b0;
      while (reset !== 1'b0)
         @(posedge clock);
      forever begin
         gap = draw_gap(rsp_mode);
         if (hold_rsp) begin
            gap      = RSP_HOLD_CYCLES;
            hold_rsp = 1'b0;
         end
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
      end
   end

   // Offers one row and returns at the edge where it was taken. When there is
   // no gap, valid simply stays high into the next beat.
   task automatic send_row(input bit [ROW_W-1:0] row);
      int gap;
      gap = draw_gap(req_mode);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.row_index <= row;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      rows_sent++;
   endtask

   // Mostly rows that exist under the present setting, so the mapping itself
   // gets exercised; the rest are drawn from the whole field.
   task automatic send_rows(input int count);
      int          n;
      int unsigned total;
      total = groups.group_total();
      for (n = 0; n < count; n++) begin
         if (total > 0 && $urandom_range(4, 0) != 0)
            send_row(ROW_W'($urandom_range(total - 1, 0)));
         else
            send_row(ROW_W'($urandom_range((1 << ROW_W) - 1, 0)));
      end
   endtask

   // Stops offering rows and waits until every pending row has come back,
   // plus a few cycles for anything still in the pipeline.
   task automatic quiesce();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (groups.pending_groups.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // A write lands at one rising edge; the model copy follows at that edge.
   task automatic write_csr(input phmap_csr_type idx, input bit [CSR_DATA_W-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      groups.set_reg(idx, data);
      csr_write_en   <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_config(input int unsigned cell_val, input int unsigned rb,
                               input int unsigned rf, input bit ext,
                               input bit [CTRL_W-1:0] pcf, input int unsigned first);
      write_csr(CSR_CELL_ID, CSR_DATA_W'(cell_val));
      write_csr(CSR_NUM_RB, CSR_DATA_W'(rb));
      write_csr(CSR_RES_FACTOR, CSR_DATA_W'(rf));
      write_csr(CSR_EXT_PREFIX, CSR_DATA_W'(ext));
      write_csr(CSR_CTRL_REGS, CSR_DATA_W'(pcf));
      write_csr(CSR_CTRL_FIRST, CSR_DATA_W'(first));
   endtask

   initial begin : stimulus
      int              phase;
      int              start_count;
      int              n_rows;
      int unsigned     cell_val, rb, rf, n0, k;
      bit [CTRL_W-1:0] pcf;

      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.row_index = '0;
      csr_write_en       = 1'b0;
      csr_index          = CSR_CELL_ID;
      csr_write_data     = '0;
      req_mode           = IDLE_NONE;
      rsp_mode           = IDLE_NONE;
      hold_rsp           = 1'b0;
      rows_sent          = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part. First the reset setting: one group, so only row 0 is
      // valid; the top of the row field must come back as an invalid row.
      send_row(0);
      send_row(1);
      send_row(63);
      quiesce();

      // Widest legal bandwidth, largest cell id, Ng = 2, PCFICH REGs spread
      // out and the comparison starting at the last entry.
      rsp_mode = IDLE_FULL;
      apply_config(503, 110, 12, 0, {9'd300, 9'd150, 9'd40, 9'd0}, 3);
      send_row(0);
      send_row(27);
      send_row(28);
      send_row(55);
      quiesce();

      // Same with extended prefix: row pairs share a group and the count
      // doubles to exactly the largest table size.
      req_mode = IDLE_FULL;
      rsp_mode = IDLE_NONE;
      apply_config(503, 110, 12, 1, {9'd300, 9'd150, 9'd40, 9'd0}, 3);
      send_row(0);
      send_row(1);
      send_row(54);
      send_row(55);
      send_row(56);
      send_row(63);
      quiesce();

      // Every field but the PCFICH start at its all-ones value: the group count saturates.
      req_mode = IDLE_NONE;
      apply_config(511, 127, 15, 1, {CTRL_W{1'b1}}, 2);
      send_row(0);
      send_row(55);
      send_row(62);
      send_row(63);
      quiesce();

      // Zero bandwidth is treated as the smallest one, and a zero resource
      // factor leaves no valid row at all.
      apply_config(0, 0, 0, 0, {9'd511, 9'd4, 9'd0, 9'd7}, 1);
      send_row(0);
      send_row(5);
      quiesce();

      // Bandwidth below the minimum with the smallest nonzero factor, PCFICH
      // REGs placed so that the index steps past several of them in turn.
      apply_config(7, 3, 1, 0, {9'd2, 9'd8, 9'd5, 9'd3}, 0);
      send_row(0);
      send_row(1);
      quiesce();

      // Random part: each phase writes a fresh setting while idle, then
      // streams rows with its own idle styles on both sides.
      phase       = 0;
      start_count = rows_sent;
      while (rows_sent - start_count < RANDOM_ROWS) begin
         case ($urandom_range(7, 0))
            0:       cell_val = 0;
            1:       cell_val = 503;
            2:       cell_val = 511;
            default: cell_val = $urandom_range(503, 0);
         endcase
         case ($urandom_range(9, 0))
            0:       rb = MIN_RB;
            1:       rb = 110;
            2:       rb = 127;
            3:       rb = $urandom_range(MIN_RB - 1, 0);
            default: rb = $urandom_range(110, MIN_RB);
         endcase
         case ($urandom_range(7, 0))
            0:       rf = $urandom_range((1 << RF_W) - 1, 0);
            1:       rf = 1;
            2:       rf = 3;
            3:       rf = 6;
            default: rf = 12;
         endcase
         // PCFICH REGs mostly fall inside the n0 range so the stepping is
         // exercised; now and then the whole register is random.
         n0 = 2 * ((rb < MIN_RB) ? MIN_RB : rb) - N0_OFFSET;
         if ($urandom_range(3, 0) == 0) begin
            pcf = CTRL_W'({$urandom(), $urandom()});
         end else begin
            for (k = 0; k < PCF_N; k++)
               pcf[k*GROUP_W +: GROUP_W] = GROUP_W'($urandom_range(n0 + 3, 0));
         end
         apply_config(cell_val, rb, rf, 1'($urandom_range(1, 0)), pcf,
                      $urandom_range(3, 0));

         req_mode = $urandom_range(IDLE_FULL, IDLE_NONE);
         rsp_mode = $urandom_range(IDLE_FULL, IDLE_NONE);
         n_rows   = $urandom_range(80, 20);

         if (phase == 1) begin
            // The response side goes quiet for a long stretch while rows
            // keep coming back to back, so the pipeline fills and stalls.
            req_mode = IDLE_NONE;
            hold_rsp = 1'b1;
            send_rows(60);
         end else if (phase == 3 || $urandom_range(3, 0) == 0) begin
            // The request side pauses mid-phase until all rows are back.
            send_rows(n_rows / 2);
            quiesce();
            send_rows(n_rows - n_rows / 2);
         end else begin
            send_rows(n_rows);
         end
         quiesce();
         phase++;
      end

      if (groups.mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Guard against a hang: far beyond the slowest correct run.
   initial begin : watchdog
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== phich_reg_group_mapper_top.f =====
design/phmap_pkg.sv
design/phmap_req_if.sv
design/phmap_rsp_if.sv
design/phmap_setup.sv
design/phich_reg_group_mapper_top.sv
verif/phich_reg_group_mapper_top_tb.sv
